// ----- rtl/cc20_pkg.sv -----
`default_nettype none
package cc20_pkg;

  // cipher constants
  localparam int unsigned ROUNDS_DEF = 20;
  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned WIDX_W     = $clog2(NUM_WORDS);
  localparam logic [31:0] SIGMA_0    = 32'h61707865;
  localparam logic [31:0] SIGMA_1    = 32'h3320646e;
  localparam logic [31:0] SIGMA_2    = 32'h79622d32;
  localparam logic [31:0] SIGMA_3    = 32'h6b206574;

  // queue between front and core
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned QPTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W   = $clog2(Q_DEPTH + 1);

  // configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0   = 3'd0,
    CFG_KEY_1   = 3'd1,
    CFG_KEY_2   = 3'd2,
    CFG_KEY_3   = 3'd3,
    CFG_NONCE_0 = 3'd4,
    CFG_NONCE_1 = 3'd5
  } cfg_idx_t;

  // channel payloads
  typedef struct packed {
    logic [31:0] data_in;
    logic [2:0]  byte_count;
    logic        first_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [2:0]  out_byte_count;
  } out_item_t;

  // classified item held in the queue
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic [3:0]  byte_mask;
    logic        first;
  } q_item_t;

  // key and nonce as state words
  typedef struct packed {
    logic [2:0][31:0] nonce;
    logic [7:0][31:0] key;
  } key_cfg_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic pop;
    logic load_out;
  } core_stat_t;

endpackage
`default_nettype wire

// ----- rtl/cc20_front.sv -----
`default_nettype none
module cc20_front
  import cc20_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  input  wire core_stat_t  core_stat,
  output logic             q_valid,
  output q_item_t          q_item,
  output front_stat_t      front_stat
);

  q_item_t                  mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]        count_r, count_nxt;
  logic                     push;
  logic                     pop;
  q_item_t                  cls;

  // classify: byte count to byte mask, above four counts as four
  always_comb begin
    cls.data  = in_data.data_in;
    cls.count = in_data.byte_count;
    cls.first = in_data.first_of_packet;
    priority if (in_data.byte_count >= 3'd4) begin
      cls.byte_mask = 4'b1111;
    end else if (in_data.byte_count == 3'd3) begin
      cls.byte_mask = 4'b0111;
    end else if (in_data.byte_count == 3'd2) begin
      cls.byte_mask = 4'b0011;
    end else if (in_data.byte_count == 3'd1) begin
      cls.byte_mask = 4'b0001;
    end else begin
      cls.byte_mask = 4'b0000;
    end
  end

  assign in_stall = (count_r == QCNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = core_stat.pop;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign front_stat.count = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cc20_core.sv -----
`default_nettype none
module cc20_core
  import cc20_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire key_cfg_t    key_cfg,
  input  wire logic        q_valid,
  input  wire q_item_t     q_item,
  output core_stat_t       core_stat,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  // each round is two half quarter-round steps
  localparam int unsigned PHASES = 2 * ROUNDS;
  localparam int unsigned PH_W   = $clog2(PHASES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FINAL = 4'b0100,
    S_EMIT  = 4'b1000
  } core_state_t;

  core_state_t              state_r, state_nxt;
  logic [PH_W-1:0]          phase_r, phase_nxt;
  logic [31:0]              blk_ctr_r, blk_ctr_nxt;
  logic [WIDX_W-1:0]        widx_r, widx_nxt;
  logic                     ks_rdy_r, ks_rdy_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              init_ctr_r;
  q_item_t                  item_r;
  out_item_t                out_item_r;
  logic [NUM_WORDS-1:0][31:0] ws_r, ws_step;
  logic [NUM_WORDS-1:0][31:0] ks_r;
  logic [NUM_WORDS-1:0][31:0] init_w;
  logic [31:0]              ctr_sel;
  logic                     pop;
  logic                     need_block;
  logic                     slot_free;
  logic                     load_out;
  logic [31:0]              mask32;

  assign pop        = (state_r == S_IDLE) && q_valid;
  assign need_block = q_item.first || !ks_rdy_r;
  assign slot_free  = !out_valid_r || !out_stall;
  assign load_out   = (state_r == S_EMIT) && slot_free;

  // block counter used for the block about to be made
  always_comb begin
    if (state_r == S_IDLE) begin
      ctr_sel = q_item.first ? 32'd1 : blk_ctr_r;
    end else begin
      ctr_sel = init_ctr_r;
    end
  end

  // initial block state
  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    init_w[11:4]  = key_cfg.key;
    init_w[12] = ctr_sel;
    init_w[15:13] = key_cfg.nonce;
  end

  // half of four quarter rounds, column or diagonal by phase
  always_comb begin
    logic        diag;
    logic        second;
    logic [1:0]  qa, qb, qc, qd;
    logic [31:0] a, b, c, d, a1, c1, dx, bx, d1, b1;
    diag   = phase_r[1];
    second = phase_r[0];
    ws_step = ws_r;
    for (int q = 0; q < 4; q++) begin
      qa = 2'(q);
      qb = qa + {1'b0, diag};
      qc = qa + {diag, 1'b0};
      qd = qa + {diag, diag};
      a  = ws_r[{2'b00, qa}];
      b  = ws_r[{2'b01, qb}];
      c  = ws_r[{2'b10, qc}];
      d  = ws_r[{2'b11, qd}];
      a1 = a + b;
      dx = d ^ a1;
      d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
      c1 = c + d1;
      bx = b ^ c1;
      b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
      ws_step[{2'b00, qa}] = a1;
      ws_step[{2'b01, qb}] = b1;
      ws_step[{2'b10, qc}] = c1;
      ws_step[{2'b11, qd}] = d1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    blk_ctr_nxt   = blk_ctr_r;
    widx_nxt      = widx_r;
    ks_rdy_nxt    = ks_rdy_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          phase_nxt = '0;
          state_nxt = need_block ? S_ROUND : S_EMIT;
        end
      end
      S_ROUND: begin
        phase_nxt = phase_r + 1'b1;
        if (phase_r == PH_W'(PHASES - 1)) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        blk_ctr_nxt = init_ctr_r + 32'd1;
        widx_nxt    = '0;
        ks_rdy_nxt  = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          widx_nxt      = widx_r + 1'b1;
          if (widx_r == WIDX_W'(NUM_WORDS - 1)) begin
            ks_rdy_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      blk_ctr_r   <= 32'd1;
      widx_r      <= '0;
      ks_rdy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      blk_ctr_r   <= blk_ctr_nxt;
      widx_r      <= widx_nxt;
      ks_rdy_r    <= ks_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working state, keystream block and item holding
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
      if (need_block) begin
        ws_r       <= init_w;
        init_ctr_r <= ctr_sel;
      end
    end
    if (state_r == S_ROUND) begin
      ws_r <= ws_step;
    end
    if (state_r == S_FINAL) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        ks_r[i] <= ws_r[i] + init_w[i];
      end
    end
  end

  // output register
  assign mask32 = {{8{item_r.byte_mask[3]}}, {8{item_r.byte_mask[2]}},
                   {8{item_r.byte_mask[1]}}, {8{item_r.byte_mask[0]}}};

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r.data_out       <= (item_r.data ^ ks_r[widx_r]) & mask32;
      out_item_r.out_byte_count <= item_r.count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_item_r;
  assign core_stat.pop      = pop;
  assign core_stat.load_out = load_out;

endmodule
`default_nettype wire

// ----- rtl/chacha20_stream_cipher.sv -----
`default_nettype none
// channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall | in_item_t: data word, byte count, packet start
// out_     | output    | out_valid/out_stall | out_item_t: data word, byte count
// cfg_     | input     | cfg_valid/cfg_ready | register index, 64-bit write data
//
// a word that uses a buffered keystream word goes from idle straight to the emit state in the core
// a word that needs a new block runs the round states first: one half quarter-round
// step on all four quarters per cycle, then the feed-forward add in the final state
// a new block is made on the first word of a packet and after every 16 words
// synchronous active-low reset; block counter 1, keystream buffer empty
// a two-item queue keeps taking input while the output register is stalled, until it is full
module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [63:0]  key_0_r, key_1_r, key_2_r, key_3_r, nonce_0_r;
  logic [31:0]  nonce_1_r;
  key_cfg_t     key_cfg;
  logic         q_valid;
  q_item_t      q_item;
  front_stat_t  front_stat;
  core_stat_t   core_stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_0_r   <= '0;
      key_1_r   <= '0;
      key_2_r   <= '0;
      key_3_r   <= '0;
      nonce_0_r <= '0;
      nonce_1_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_0:   key_0_r   <= cfg_data;
        CFG_KEY_1:   key_1_r   <= cfg_data;
        CFG_KEY_2:   key_2_r   <= cfg_data;
        CFG_KEY_3:   key_3_r   <= cfg_data;
        CFG_NONCE_0: nonce_0_r <= cfg_data;
        CFG_NONCE_1: nonce_1_r <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign key_cfg.key   = {key_3_r, key_2_r, key_1_r, key_0_r};
  assign key_cfg.nonce = {nonce_1_r, nonce_0_r};

  // front: accept and classify items
  cc20_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .core_stat  (core_stat),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .front_stat (front_stat)
  );

  // core: keystream blocks and xor
  cc20_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_cfg   (key_cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .core_stat (core_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.count <= QCNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  // core only takes an item that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.pop |-> (front_stat.count != '0))
    else $error("core took an item from an empty queue");

  // output register never overwritten while a result waits
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.load_out |-> !(out_valid && out_stall))
    else $error("output register loaded while stalled");

  // a result appears only after the core loaded it
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(core_stat.load_out))
    else $error("result appeared without a load");

endmodule
`default_nettype wire

// ----- verif/chacha20_stream_cipher_tb.sv -----
`timescale 1ns / 100ps
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned PHASE_WORDS    = 335;
  localparam int unsigned REPORT_LIMIT   = 10;

  // register indexes outside the map, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // keeps a software copy of the keystream generator and the words it owes
  class cipher_word_checker;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] next_ctr;
    logic [31:0] ks_buf [16];
    logic [31:0] ws [16];
    logic [3:0]  ks_pos;
    bit          ks_valid;
    out_item_t   expected_words [$];
    int unsigned failures;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      nonce_lo  = '0;
      nonce_hi  = '0;
      next_ctr  = 32'd1;
      ks_pos    = '0;
      ks_valid  = 1'b0;
      failures  = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_round(int a, int b, int c, int d);
      ws[a] = ws[a] + ws[b];
      ws[d] = rotl(ws[d] ^ ws[a], 16);
      ws[c] = ws[c] + ws[d];
      ws[b] = rotl(ws[b] ^ ws[c], 12);
      ws[a] = ws[a] + ws[b];
      ws[d] = rotl(ws[d] ^ ws[a], 8);
      ws[c] = ws[c] + ws[d];
      ws[b] = rotl(ws[b] ^ ws[c], 7);
    endfunction

    // one 64-byte block for the current counter, then advance the counter
    function void make_block();
      logic [31:0] init [16];
      int i;
      init[0]  = SIGMA_0;
      init[1]  = SIGMA_1;
      init[2]  = SIGMA_2;
      init[3]  = SIGMA_3;
      for (i = 0; i < 4; i++) begin
        init[4 + 2 * i] = key_reg[i][31:0];
        init[5 + 2 * i] = key_reg[i][63:32];
      end
      init[12] = next_ctr;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      for (i = 0; i < 16; i++) ws[i] = init[i];
      // column rounds then diagonal rounds
      for (i = 0; i < ROUNDS_DEF / 2; i++) begin
        quarter_round(0, 4, 8, 12);
        quarter_round(1, 5, 9, 13);
        quarter_round(2, 6, 10, 14);
        quarter_round(3, 7, 11, 15);
        quarter_round(0, 5, 10, 15);
        quarter_round(1, 6, 11, 12);
        quarter_round(2, 7, 8, 13);
        quarter_round(3, 4, 9, 14);
      end
      for (i = 0; i < 16; i++) ks_buf[i] = ws[i] + init[i];
      next_ctr = next_ctr + 32'd1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        CFG_KEY_0:   key_reg[0] = value;
        CFG_KEY_1:   key_reg[1] = value;
        CFG_KEY_2:   key_reg[2] = value;
        CFG_KEY_3:   key_reg[3] = value;
        CFG_NONCE_0: nonce_lo   = value;
        CFG_NONCE_1: nonce_hi   = value[31:0];
        default: ;
      endcase
    endfunction

    // accepted input item: work out the cipher word it must produce
    function void note_word(in_item_t it);
      logic [31:0] ks;
      logic [31:0] mask;
      out_item_t   exp_word;
      if (it.first_of_packet) begin
        next_ctr = 32'd1;
        ks_valid = 1'b0;
      end
      if (!ks_valid) begin
        make_block();
        ks_pos   = '0;
        ks_valid = 1'b1;
      end
      ks     = ks_buf[ks_pos];
      ks_pos = ks_pos + 4'd1;
      if (ks_pos == 4'd0) ks_valid = 1'b0;
      // counts above four behave as four, zero masks everything
      if (it.byte_count >= 3'd4) mask = '1;
      else mask = (32'h1 << (8 * it.byte_count)) - 32'h1;
      exp_word.data_out       = (it.data_in ^ ks) & mask;
      exp_word.out_byte_count = it.byte_count;
      expected_words.push_back(exp_word);
    endfunction

    function void flag(string what, out_item_t want, out_item_t got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%s: expected data %08h count %0d, got data %08h count %0d",
                 what, want.data_out, want.out_byte_count, got.data_out, got.out_byte_count);
    endfunction

    // accepted result item: compare with the oldest word owed
    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        flag("result with nothing pending", '0, got);
        return;
      end
      want = expected_words.pop_front();
      if (got.data_out !== want.data_out)
        flag("data_out mismatch", want, got);
      else if (got.out_byte_count !== want.out_byte_count)
        flag("out_byte_count mismatch", want, got);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  cipher_word_checker words_sb;

  chacha20_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) words_sb.note_word(in_data);
      if (out_valid && !out_stall) words_sb.check_word(out_data);
      if (cfg_valid && cfg_ready) words_sb.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("chacha20_stream_cipher regression: fail");
      $finish;
    end
  end

  // mostly random data, with the all-zero and all-one words mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_word(logic [31:0] data, logic [2:0] count, logic first);
    in_item_t word;
    word.data_in         = data;
    word.byte_count      = count;
    word.first_of_packet = first;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every owed word has come back, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_key_nonce(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                logic [63:0] k3, logic [63:0] n0, logic [63:0] n1);
    write_cfg(CFG_KEY_0, k0);
    write_cfg(CFG_SPARE_6, {$urandom, $urandom});
    write_cfg(CFG_KEY_1, k1);
    write_cfg(CFG_KEY_2, k2);
    write_cfg(CFG_KEY_3, k3);
    write_cfg(CFG_SPARE_7, {$urandom, $urandom});
    write_cfg(CFG_NONCE_0, n0);
    write_cfg(CFG_NONCE_1, n1);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned plen;
    int unsigned i;
    logic [2:0]  cnt;
    words_sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, all-zero key from reset; first word after reset has no start mark
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b0);
    // every byte count including zero and the ones above four
    for (i = 0; i < 8; i++) begin
      if (i != 4) send_word(32'hffff_ffff, i[2:0], 1'b0);
    end
    // run past the first block into the second
    for (i = 0; i < 9; i++) send_word(32'h0101_0101 * i, 3'd4, 1'b0);
    // restart mid-block, partial word, keystream continuing after it
    send_word(32'h1234_5678, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b0);
    send_word(32'hdead_beef, 3'd4, 1'b0);
    // one-word partial packet, then a fresh packet
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'h8000_0001, 3'd4, 1'b1);
    send_word(32'h0000_0001, 3'd4, 1'b0);

    for (phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: load_key_nonce('1, '1, '1, '1, '1, '1);
        1: load_key_nonce(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                          64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                          64'h4a00_0000_0000_0000, 64'h0);
        default: load_key_nonce({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 72;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 72;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase

      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(99) < 85) begin
          // well-formed packet, sometimes long enough to span several blocks
          if ($urandom_range(9) == 0) plen = $urandom_range(33, 70);
          else plen = $urandom_range(1, 20);
          for (i = 0; i < plen; i++) begin
            cnt = 3'd4;
            if (i == plen - 1 && $urandom_range(1) == 1) cnt = 3'($urandom_range(1, 4));
            send_word(pick_word(), cnt, i == 0);
          end
        end else begin
          // noise: any byte count, start marks anywhere
          plen = $urandom_range(1, 6);
          for (i = 0; i < plen; i++) begin
            cnt = 3'($urandom_range(7));
            send_word(pick_word(), cnt, $urandom_range(3) == 0);
          end
        end
        sent += plen;
      end
    end

    drain();
    if (words_sb.failures == 0) begin
      $display("chacha20_stream_cipher regression: pass");
    end else begin
      $display("chacha20_stream_cipher regression: fail");
    end
    $finish;
  end

endmodule
